FILE: rtl/wsp_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the WAV stream parser and player.
// No dependencies; imported by every module of the block.
package wsp_pkg;

    // Result status codes
    localparam logic [2:0] ST_SAMPLE    = 3'd0;
    localparam logic [2:0] ST_FORMAT_OK = 3'd1;
    localparam logic [2:0] ST_NOT_WAV   = 3'd2;
    localparam logic [2:0] ST_BAD_FMT   = 3'd3;
    localparam logic [2:0] ST_NOT_MONO  = 3'd4;
    localparam logic [2:0] ST_PLAY_END  = 3'd5;

    // Configuration space: register index taken from paddr[2]
    localparam int         ADDR_W       = 3;
    localparam logic       IDX_VOLUME   = 1'b0;
    localparam logic [6:0] VOLUME_RESET = 7'd35;

    // Queue between parser and player
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Reciprocal of 100: floor(p / 100) == (p * 5243) >> 19 for p below 2**15
    localparam logic [12:0] RECIP_100  = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  sample;
        logic [31:0] rate;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    typedef struct packed {
        logic           empty;
        logic           full;
        logic [QCW-1:0] count;
    } qstat_t;

endpackage

FILE: rtl/wsp_front.sv
`timescale 1ns / 1ps
// Front end: RIFF/WAVE byte parser; classifies each byte and issues
// at most one result record per transfer. Depends on wsp_pkg.
module wsp_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic          command,
    input  logic [7:0]    data_byte,
    output wsp_pkg::push_t push
);
    import wsp_pkg::*;

    localparam logic [2:0] PH_RIFF = 3'd0;
    localparam logic [2:0] PH_FMTH = 3'd1;
    localparam logic [2:0] PH_FMTB = 3'd2;
    localparam logic [2:0] PH_CHNK = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_SKIP = 3'd5;
    localparam logic [2:0] PH_HALT = 3'd6;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    logic [2:0]  phase_reg, phase_next;
    logic [4:0]  hcnt_reg, hcnt_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] left_reg, left_next;
    logic [4:0]  fsize_reg, fsize_next;
    logic [15:0] chan_reg, chan_next;
    logic [15:0] bps_reg, bps_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] extra_reg, extra_next;
    logic        riff_bad_reg, riff_bad_next;

    logic [4:0]  cnt_inc;
    logic [31:0] lane32;
    logic [15:0] lane16;

    assign cnt_inc = hcnt_reg + 5'd1;
    // byte placed in its little-endian lane
    assign lane32  = {24'd0, data_byte} << {hcnt_reg[1:0], 3'b000};
    assign lane16  = {8'd0, data_byte} << {hcnt_reg[0], 3'b000};

    // Parser next state and result record
    always_comb
    begin
        phase_next    = phase_reg;
        hcnt_next     = hcnt_reg;
        tag_next      = tag_reg;
        left_next     = left_reg;
        fsize_next    = fsize_reg;
        chan_next     = chan_reg;
        bps_next      = bps_reg;
        rate_next     = rate_reg;
        extra_next    = extra_reg;
        riff_bad_next = riff_bad_reg;
        push.valid        = 1'b0;
        push.entry.status = ST_SAMPLE;
        push.entry.sample = 8'd0;
        push.entry.rate   = 32'd0;

        if (accept) begin
            if (command) begin
                // end of file: report by phase, then restart
                phase_next    = PH_RIFF;
                hcnt_next     = 5'd0;
                tag_next      = 32'd0;
                left_next     = 32'd0;
                fsize_next    = 5'd0;
                chan_next     = 16'd0;
                bps_next      = 16'd0;
                rate_next     = 32'd0;
                extra_next    = 16'd0;
                riff_bad_next = 1'b0;
                unique case (phase_reg) inside
                    PH_RIFF:
                    begin
                        push.valid        = 1'b1;
                        push.entry.status = ST_NOT_WAV;
                    end
                    PH_FMTH, PH_FMTB:
                    begin
                        push.valid        = 1'b1;
                        push.entry.status = ST_BAD_FMT;
                    end
                    PH_CHNK, PH_DATA, PH_SKIP:
                    begin
                        push.valid        = 1'b1;
                        push.entry.status = ST_PLAY_END;
                    end
                    default:
                    begin
                    end
                endcase
            end else begin
                unique case (phase_reg) inside
                    PH_RIFF:
                    begin
                        tag_next  = {tag_reg[23:0], data_byte};
                        hcnt_next = cnt_inc;
                        if (cnt_inc == 5'd4 && tag_next != TAG_RIFF)
                            riff_bad_next = 1'b1;
                        if (cnt_inc == 5'd12) begin
                            hcnt_next = 5'd0;
                            if (riff_bad_next || tag_next != TAG_WAVE) begin
                                phase_next        = PH_HALT;
                                push.valid        = 1'b1;
                                push.entry.status = ST_NOT_WAV;
                            end else begin
                                phase_next = PH_FMTH;
                                tag_next   = 32'd0;
                            end
                        end
                    end
                    PH_FMTH, PH_CHNK:
                    begin
                        // four tag bytes, then a little-endian size
                        if (hcnt_reg < 5'd4)
                            tag_next = {tag_reg[23:0], data_byte};
                        else
                            left_next = left_reg | lane32;
                        hcnt_next = cnt_inc;
                        if (cnt_inc == 5'd8) begin
                            hcnt_next = 5'd0;
                            if (phase_reg == PH_FMTH) begin
                                if (tag_next != TAG_FMT ||
                                    (left_next != 32'd16 && left_next != 32'd18)) begin
                                    phase_next        = PH_HALT;
                                    push.valid        = 1'b1;
                                    push.entry.status = ST_BAD_FMT;
                                end else begin
                                    fsize_next = left_next[4:0];
                                    left_next  = 32'd0;
                                    phase_next = PH_FMTB;
                                end
                            end else if (tag_next == TAG_DATA) begin
                                if (left_next == 32'd0) begin
                                    phase_next        = PH_HALT;
                                    push.valid        = 1'b1;
                                    push.entry.status = ST_PLAY_END;
                                end else begin
                                    phase_next = PH_DATA;
                                end
                            end else if (left_next != 32'd0) begin
                                phase_next = PH_SKIP;
                            end else begin
                                // empty chunk: straight on to the next header
                                tag_next = 32'd0;
                            end
                        end
                    end
                    PH_FMTB:
                    begin
                        case (hcnt_reg) inside
                            [5'd2:5'd3]:   chan_next  = chan_reg | lane16;
                            [5'd4:5'd7]:   rate_next  = rate_reg | lane32;
                            [5'd14:5'd15]: bps_next   = bps_reg | lane16;
                            [5'd16:5'd17]: extra_next = extra_reg | lane16;
                            default:
                            begin
                            end
                        endcase
                        hcnt_next = cnt_inc;
                        if (cnt_inc >= fsize_reg) begin
                            hcnt_next  = 5'd0;
                            tag_next   = 32'd0;
                            phase_next = PH_HALT;
                            push.valid = 1'b1;
                            if (fsize_reg == 5'd18 && extra_next != 16'd0) begin
                                push.entry.status = ST_BAD_FMT;
                            end else if (chan_next != 16'd1 || bps_next != 16'd8) begin
                                push.entry.status = ST_NOT_MONO;
                            end else begin
                                phase_next        = PH_CHNK;
                                push.entry.status = ST_FORMAT_OK;
                                push.entry.rate   = rate_next;
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        push.valid        = 1'b1;
                        push.entry.status = ST_SAMPLE;
                        push.entry.sample = data_byte;
                        left_next         = left_reg - 32'd1;
                        if (left_reg == 32'd1) begin
                            phase_next = PH_CHNK;
                            tag_next   = 32'd0;
                        end
                    end
                    PH_SKIP:
                    begin
                        left_next = left_reg - 32'd1;
                        if (left_reg == 32'd1) begin
                            phase_next = PH_CHNK;
                            tag_next   = 32'd0;
                        end
                    end
                    default:
                    begin
                        // halted: wait for end of file
                    end
                endcase
            end
        end
    end

    // Parser registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg    <= PH_RIFF;
            hcnt_reg     <= 5'd0;
            tag_reg      <= 32'd0;
            left_reg     <= 32'd0;
            fsize_reg    <= 5'd0;
            chan_reg     <= 16'd0;
            bps_reg      <= 16'd0;
            rate_reg     <= 32'd0;
            extra_reg    <= 16'd0;
            riff_bad_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            hcnt_reg     <= hcnt_next;
            tag_reg      <= tag_next;
            left_reg     <= left_next;
            fsize_reg    <= fsize_next;
            chan_reg     <= chan_next;
            bps_reg      <= bps_next;
            rate_reg     <= rate_next;
            extra_reg    <= extra_next;
            riff_bad_reg <= riff_bad_next;
        end
    end

endmodule

FILE: rtl/wsp_queue.sv
`timescale 1ns / 1ps
// Short FIFO of result records between parser and player.
// Depends on wsp_pkg for the record type and depth.
module wsp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  wsp_pkg::push_t  push,
    input  logic            pop,
    output wsp_pkg::entry_t head,
    output wsp_pkg::qstat_t stat
);
    import wsp_pkg::*;

    entry_t         mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QCW-1:0] count_reg;
    logic           do_push;
    logic           do_pop;

    assign do_push    = push.valid && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QCW'(QDEPTH));
    assign stat.count = count_reg;
    assign head       = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push.entry;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + QCW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - QCW'(1);
        end
    end

endmodule

FILE: rtl/wsp_back.sv
`timescale 1ns / 1ps
// Back end: volume scaling of samples in two stages, the second being the output register.
// Depends on wsp_pkg for record type, status codes and reciprocal.
module wsp_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  wsp_pkg::entry_t head,
    input  logic [6:0]      volume,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [2:0]      status,
    output logic [7:0]      sample_out,
    output logic [31:0]     sample_rate
);
    import wsp_pkg::*;

    logic        s1_valid_reg;
    logic [2:0]  s1_status_reg;
    logic [14:0] s1_prod_reg;
    logic [31:0] s1_rate_reg;
    logic        out_valid_reg;
    logic [2:0]  status_reg;
    logic [7:0]  sample_reg;
    logic [31:0] rate_reg;

    logic        out_free;
    logic        s1_free;
    logic [27:0] recip_prod;
    logic [8:0]  quot;
    logic [7:0]  scaled;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_free  = !s1_valid_reg || out_free;
    assign pop      = head_valid && s1_free;

    // floor(product / 100), saturated to a byte
    assign recip_prod = 28'(s1_prod_reg) * 28'(RECIP_100);
    assign quot       = recip_prod[RECIP_SHIFT +: 9];
    assign scaled     = quot[8] ? 8'hFF : quot[7:0];

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_free)
                s1_valid_reg <= head_valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Stage payloads: byte times gain, then divide and present
    always_ff @(posedge clk)
    begin
        if (s1_free) begin
            s1_status_reg <= head.status;
            s1_prod_reg   <= 15'(head.sample) * 15'(volume);
            s1_rate_reg   <= head.rate;
        end
        if (out_free) begin
            status_reg <= s1_status_reg;
            sample_reg <= (s1_status_reg == ST_SAMPLE) ? scaled : 8'd0;
            rate_reg   <= s1_rate_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign sample_out  = sample_reg;
    assign sample_rate = rate_reg;

endmodule

FILE: rtl/wav_stream_parser_player.sv
`timescale 1ns / 1ps
// WAV stream parser and player: top level with the APB register port.
// Depends on wsp_pkg, wsp_front, wsp_queue and wsp_back.

// One file byte (or end-of-file mark) is taken per clock while in_stall is low.
// The parser answers in the same cycle and pushes at most one record into a
// four-entry queue; the player scales samples as floor(byte * volume / 100),
// saturating at 255. A result passes the queue, the gain-multiply register and
// the output register in that order: the record enters the queue on the
// accepting edge, the gain multiply is then registered and the reciprocal
// multiply lands in the output register after it. Sustained rate is one byte
// per clock; in_stall rises only when the queue is full because the output side
// is held. There is no clearing pass after reset. volume_percent (reset 35) sits
// at byte address 0 and should be written only while idle.
module wav_stream_parser_player (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      command,
    input  logic [7:0]                data_byte,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [2:0]                status,
    output logic [7:0]                sample_out,
    output logic [31:0]               sample_rate,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [wsp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import wsp_pkg::*;

    logic [6:0] volume_reg;
    logic       accept;
    logic       pop;
    push_t      push;
    entry_t     head;
    qstat_t     qstat;

    // Register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == IDX_VOLUME) ? {25'd0, volume_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            volume_reg <= VOLUME_RESET;
        else if (psel && penable && pwrite && paddr[2] == IDX_VOLUME)
            volume_reg <= pwdata[6:0];
    end

    // Input transfer
    assign in_stall = qstat.full;
    assign accept   = in_valid && !in_stall;

    wsp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .command   (command),
        .data_byte (data_byte),
        .push      (push)
    );

    wsp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .stat  (qstat)
    );

    wsp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (!qstat.empty),
        .head        (head),
        .volume      (volume_reg),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .sample_out  (sample_out),
        .sample_rate (sample_rate)
    );

`ifndef SYNTH
    // a record is never offered to a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push.valid && qstat.full))
        else $error("record pushed into full queue");

    // a push without a pop raises the fill count by one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && !pop) |=> (qstat.count == $past(qstat.count) + 1'b1))
        else $error("queue count did not follow push");

    // only sample results carry a sample value
    a_sample_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_SAMPLE) |-> (sample_out == 8'd0))
        else $error("non-sample result with sample value");

    // only a format verdict carries a rate
    a_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_FORMAT_OK) |-> (sample_rate == 32'd0))
        else $error("rate reported outside format verdict");
`endif

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for wav_stream_parser_player: random WAV files go in as byte transfers.
// The scoreboard predicts each result. Depends on wsp_pkg and the RTL only.

// Four-character chunk tags, first character in the top byte
localparam logic [31:0] TAG_RIFF = "RIFF";
localparam logic [31:0] TAG_WAVE = "WAVE";
localparam logic [31:0] TAG_FMT  = "fmt ";
localparam logic [31:0] TAG_DATA = "data";

typedef enum logic [2:0] {
    WAIT_RIFF,
    WAIT_FMT_HDR,
    IN_FMT_BODY,
    IN_CHUNK_HDR,
    IN_DATA,
    IN_SKIP,
    HALTED
} parse_phase_t;

// Parser and gain predictor plus the store of expected results
class wav_scoreboard;
    logic [6:0]     volume;
    parse_phase_t   phase;
    logic [4:0]     hdr_count;
    logic [31:0]    tag;
    logic [31:0]    bytes_left;
    logic [4:0]     fmt_size;
    logic [15:0]    channels;
    logic [15:0]    bits_per_smp;
    logic [15:0]    extra_len;
    logic [31:0]    rate;
    bit             riff_bad;
    wsp_pkg::entry_t pending_results[$];
    int             failures;
    int             results_checked;

    function new();
        volume          = wsp_pkg::VOLUME_RESET;
        failures        = 0;
        results_checked = 0;
        restart();
    endfunction

    function void restart();
        phase        = WAIT_RIFF;
        hdr_count    = '0;
        tag          = '0;
        bytes_left   = '0;
        fmt_size     = '0;
        channels     = '0;
        bits_per_smp = '0;
        extra_len    = '0;
        rate         = '0;
        riff_bad     = 1'b0;
    endfunction

    function void queue_result(logic [2:0] st, logic [7:0] smp, logic [31:0] r);
        wsp_pkg::entry_t e;
        e.status = st;
        e.sample = smp;
        e.rate   = r;
        pending_results.push_back(e);
    endfunction

    // Work out what one accepted input transfer produces
    function void note_item(logic cmd, logic [7:0] b);
        parse_phase_t was;
        int           n;
        logic [14:0]  prod;
        int           scaled;
        if (cmd)
        begin
            // end of file: verdict depends on where we were, then start afresh
            was = phase;
            restart();
            case (was)
                WAIT_RIFF:                   queue_result(wsp_pkg::ST_NOT_WAV, 8'd0, 32'd0);
                WAIT_FMT_HDR, IN_FMT_BODY:   queue_result(wsp_pkg::ST_BAD_FMT, 8'd0, 32'd0);
                IN_CHUNK_HDR, IN_DATA, IN_SKIP:
                                             queue_result(wsp_pkg::ST_PLAY_END, 8'd0, 32'd0);
                default: ;
            endcase
            return;
        end
        case (phase)
            WAIT_RIFF:
            begin
                tag       = {tag[23:0], b};
                hdr_count = hdr_count + 5'd1;
                if (hdr_count == 5'd4 && tag != TAG_RIFF)
                    riff_bad = 1'b1;
                if (hdr_count == 5'd12)
                begin
                    hdr_count = '0;
                    if (riff_bad || tag != TAG_WAVE)
                    begin
                        phase = HALTED;
                        queue_result(wsp_pkg::ST_NOT_WAV, 8'd0, 32'd0);
                    end
                    else
                    begin
                        phase = WAIT_FMT_HDR;
                        tag   = '0;
                    end
                end
            end
            WAIT_FMT_HDR, IN_CHUNK_HDR:
            begin
                // four tag bytes, then a little-endian length
                n = hdr_count;
                if (n < 4)
                    tag = {tag[23:0], b};
                else
                    bytes_left[8*(n-4) +: 8] = b;
                hdr_count = hdr_count + 5'd1;
                if (hdr_count == 5'd8)
                begin
                    hdr_count = '0;
                    if (phase == WAIT_FMT_HDR)
                    begin
                        if (tag != TAG_FMT || (bytes_left != 32'd16 && bytes_left != 32'd18))
                        begin
                            phase = HALTED;
                            queue_result(wsp_pkg::ST_BAD_FMT, 8'd0, 32'd0);
                        end
                        else
                        begin
                            fmt_size   = bytes_left[4:0];
                            bytes_left = '0;
                            phase      = IN_FMT_BODY;
                        end
                    end
                    else if (tag == TAG_DATA)
                    begin
                        if (bytes_left == 32'd0)
                        begin
                            phase = HALTED;
                            queue_result(wsp_pkg::ST_PLAY_END, 8'd0, 32'd0);
                        end
                        else
                            phase = IN_DATA;
                    end
                    else if (bytes_left != 32'd0)
                        phase = IN_SKIP;
                    else
                        tag = '0;
                end
            end
            IN_FMT_BODY:
            begin
                n = hdr_count;
                if (n == 2 || n == 3)
                    channels[8*(n-2) +: 8] = b;
                else if (n >= 4 && n <= 7)
                    rate[8*(n-4) +: 8] = b;
                else if (n == 14 || n == 15)
                    bits_per_smp[8*(n-14) +: 8] = b;
                else if (n == 16 || n == 17)
                    extra_len[8*(n-16) +: 8] = b;
                hdr_count = hdr_count + 5'd1;
                if (hdr_count >= fmt_size)
                begin
                    hdr_count = '0;
                    tag       = '0;
                    if (fmt_size == 5'd18 && extra_len != 16'd0)
                    begin
                        phase = HALTED;
                        queue_result(wsp_pkg::ST_BAD_FMT, 8'd0, 32'd0);
                    end
                    else if (channels != 16'd1 || bits_per_smp != 16'd8)
                    begin
                        phase = HALTED;
                        queue_result(wsp_pkg::ST_NOT_MONO, 8'd0, 32'd0);
                    end
                    else
                    begin
                        phase = IN_CHUNK_HDR;
                        queue_result(wsp_pkg::ST_FORMAT_OK, 8'd0, rate);
                    end
                end
            end
            IN_DATA, IN_SKIP:
            begin
                if (phase == IN_DATA)
                begin
                    // floor(byte * percent / 100), clipped for gains above 100
                    prod   = b * volume;
                    scaled = prod / 100;
                    if (scaled > 255)
                        scaled = 255;
                    queue_result(wsp_pkg::ST_SAMPLE, scaled[7:0], 32'd0);
                end
                bytes_left = bytes_left - 32'd1;
                if (bytes_left == 32'd0)
                begin
                    phase = IN_CHUNK_HDR;
                    tag   = '0;
                end
            end
            default: ;
        endcase
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(logic [2:0] st, logic [7:0] smp, logic [31:0] r);
        wsp_pkg::entry_t e;
        if (pending_results.size() == 0)
        begin
            $error("unexpected result: status=%0d sample=%0d rate=%0d", st, smp, r);
            failures++;
            return;
        end
        e = pending_results.pop_front();
        results_checked++;
        if (st !== e.status)
        begin
            $error("status: expected %0d, got %0d", e.status, st);
            failures++;
        end
        if (smp !== e.sample)
        begin
            $error("sample_out: expected %0d, got %0d", e.sample, smp);
            failures++;
        end
        if (r !== e.rate)
        begin
            $error("sample_rate: expected %0d, got %0d", e.rate, r);
            failures++;
        end
    endfunction
endclass

module tb_top;
    import wsp_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                command;
    logic [7:0]          data_byte;
    logic                out_valid;
    logic                out_stall;
    logic [2:0]          status;
    logic [7:0]          sample_out;
    logic [31:0]         sample_rate;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    wav_scoreboard sb = new();

    // {command, byte} transfers waiting to go in
    logic [8:0]  stim_q[$];
    logic [7:0]  file_bytes[$];
    int          queued_items   = 0;
    int          accepted_items = 0;
    int          files_sent     = 0;
    int          gain_settings  = 1;
    int          phase_no       = 0;
    int          idle_mode      = 0;
    bit          long_hold_done = 1'b0;

    wav_stream_parser_player dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .sample_out  (sample_out),
        .sample_rate (sample_rate),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle cycles per transfer: none, fully random, or mostly back-to-back
    function automatic int draw_wait();
        case (idle_mode)
            0:       return 0;
            1:       return $urandom_range(0, 18);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
        endcase
    endfunction

    function automatic void put_le(logic [31:0] v, int nbytes);
        for (int i = 0; i < nbytes; i++)
            file_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_tag(logic [31:0] t);
        for (int i = 3; i >= 0; i--)
            file_bytes.push_back(t[8*i +: 8]);
    endfunction

    // Queue the built file as byte transfers followed by an end-of-file mark
    function automatic void flush_file();
        foreach (file_bytes[i])
            stim_q.push_back({1'b0, file_bytes[i]});
        stim_q.push_back({1'b1, 8'($urandom)});
        queued_items += file_bytes.size() + 1;
        files_sent++;
        file_bytes.delete();
    endfunction

    // One random file: mostly well formed, some with a broken format or damaged
    task automatic add_wav_file();
        int unsigned style;
        int unsigned fmt_len;
        int unsigned len;
        int unsigned pos;
        logic [15:0] ch;
        logic [15:0] bps;
        logic [31:0] r;
        file_bytes.delete();
        style = $urandom_range(0, 18);
        if (style == 18)
        begin
            // plain noise
            repeat ($urandom_range(1, 30))
                file_bytes.push_back(8'($urandom));
            flush_file();
            return;
        end
        put_tag(TAG_RIFF);
        put_le($urandom, 4);
        put_tag(TAG_WAVE);
        fmt_len = $urandom_range(0, 1) ? 16 : 18;
        if (style == 14)
            fmt_len = 18;
        put_tag(TAG_FMT);
        put_le((style == 15) ? $urandom_range(0, 40) : fmt_len, 4);
        ch = 16'd1;
        if (style == 12)
            ch = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(2, 65535));
        bps = 16'd8;
        if (style == 13)
        begin
            bps = 16'($urandom_range(0, 65535));
            if (bps == 16'd8)
                bps = 16'd16;
        end
        case ($urandom_range(0, 3))
            0:       r = 32'hFFFF_FFFF;
            1:       r = 32'd0;
            default: r = $urandom;
        endcase
        put_le($urandom, 2);            // format code, not looked at
        put_le(ch, 2);
        put_le(r, 4);
        put_le($urandom, 4);            // byte rate
        put_le($urandom, 2);            // block align
        put_le(bps, 2);
        if (fmt_len == 18)
            put_le((style == 14) ? 32'($urandom_range(1, 65535)) : 32'd0, 2);
        // chunk walk: skipped chunks and data chunks
        repeat ($urandom_range(0, 4))
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                len = $urandom_range(0, 6);
                put_tag($urandom);
                put_le(len, 4);
                repeat (len)
                    file_bytes.push_back(8'($urandom));
            end
            else
            begin
                len = $urandom_range(1, 40);
                put_tag(TAG_DATA);
                // now and then a length far longer than the bytes that follow
                if ($urandom_range(0, 15) == 0)
                    put_le(len | ($urandom << 8), 4);
                else
                    put_le(len, 4);
                repeat (len)
                    file_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom));
            end
        end
        if ($urandom_range(0, 1))
        begin
            // empty data chunk ends playback; trailing bytes are ignored
            put_tag(TAG_DATA);
            put_le(32'd0, 4);
            repeat ($urandom_range(0, 3))
                file_bytes.push_back(8'($urandom));
        end
        if (style == 16)
        begin
            pos = $urandom_range(0, file_bytes.size() - 1);
            file_bytes[pos] = file_bytes[pos] ^ 8'($urandom_range(1, 255));
        end
        else if (style == 17)
        begin
            pos = $urandom_range(0, file_bytes.size() - 1);
            while (file_bytes.size() > pos)
                void'(file_bytes.pop_back());
        end
        flush_file();
    endtask

    // Wait until every transfer is in and every result is out, then let the pipe empty
    task automatic settle();
        int cycles;
        cycles = 0;
        while ((accepted_items != queued_items || sb.pending_results.size() != 0)
               && cycles < 20000)
        begin
            @(posedge clk);
            cycles++;
        end
        repeat (8) @(posedge clk);
    endtask

    // Register write followed by a read back
    task automatic write_volume(input logic [6:0] vol);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {IDX_VOLUME, 2'b00};
        pwdata  <= {25'd0, vol};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.volume = vol;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[6:0] !== vol)
        begin
            $error("volume_percent: expected %0d, got %0d", vol, prdata[6:0]);
            sb.failures++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        gain_settings++;
    endtask

    // Input side: one transfer per item, random idle cycles in between
    initial
    begin : byte_source
        logic [8:0] item;
        int         gap;
        in_valid  <= 1'b0;
        command   <= 1'b0;
        data_byte <= 8'd0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (stim_q.size() == 0)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                gap = draw_wait();
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                item = stim_q.pop_front();
                in_valid  <= 1'b1;
                command   <= item[8];
                data_byte <= item[7:0];
                do @(posedge clk); while (in_stall);
                sb.note_item(item[8], item[7:0]);
                accepted_items++;
            end
        end
    end

    // Output side: random stalls, plus one long hold-off to fill the queue
    initial
    begin : result_sink
        int hold;
        out_stall <= 1'b0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (!long_hold_done && phase_no == 3 && stim_q.size() > 100)
            begin
                long_hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                hold = draw_wait();
                if (hold > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (hold) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
            do @(posedge clk); while (!out_valid);
            sb.check_result(status, sample_out, sample_rate);
        end
    end

    // Sequence: reset, short directed files, then random files over several gains
    initial
    begin : run_control
        int         target;
        logic [6:0] gains[7];
        gains = '{7'd35, 7'd0, 7'd100, 7'd127, 7'd1, 7'($urandom_range(2, 99)), 7'd64};
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // end of file straight after reset
        flush_file();
        // bad form tag on the twelfth byte, then end of file while halted
        put_tag(TAG_RIFF);
        put_le(32'hFFFF_FFFF, 4);
        put_tag("WAVX");
        flush_file();
        // bad RIFF tag with a good WAVE tag
        put_le(32'd0, 4);
        put_le(32'd0, 4);
        put_tag(TAG_WAVE);
        flush_file();

        for (phase_no = 0; phase_no < 7; phase_no++)
        begin
            settle();
            if (phase_no > 0)
                write_volume(gains[phase_no]);
            idle_mode = phase_no % 3;
            target = queued_items + 150;
            while (queued_items < target)
                add_wav_file();
        end
        settle();

        if (sb.pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending_results.size());
            sb.failures++;
        end
        $display("Ran %0d files as %0d input transfers under %0d gain settings.",
                 files_sent, accepted_items, gain_settings);
        $display("Checked %0d results; long output hold-off %s.", sb.results_checked,
                 long_hold_done ? "exercised" : "not reached");
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
